/* rtl/core/single_wire_led_frame_serializer_macros.svh */
// Assertion macros shared by the serializer's checker.
`ifndef SINGLE_WIRE_LED_FRAME_SERIALIZER_MACROS_SVH
`define SINGLE_WIRE_LED_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SWLFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("serializer check failed");

// Next-cycle implication, disabled while reset is low.
`define SWLFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("serializer check failed");

`endif

/* rtl/core/swlfs_pkg.sv */
// Package: types, sizes and register reset values of the LED frame serializer.
`default_nettype none

package swlfs_pkg;

    localparam int FRAME_BITS = 48;
    localparam int WORD_BITS  = 12;
    localparam int FULL_BITS  = 4 * WORD_BITS;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int COUNT_W    = 12;
    localparam int LEVEL_W    = 12;
    localparam int SHORT_W    = 8;
    localparam int LONG_W     = 12;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_HIGH  = 3'd0,
        REG_FIRST_LOW   = 3'd1,
        REG_SECOND_HIGH = 3'd2,
        REG_ONE_TAIL    = 3'd3,
        REG_ZERO_TAIL   = 3'd4,
        REG_END_WAIT    = 3'd5,
        REG_LATCH_WAIT  = 3'd6,
        REG_COMMAND     = 3'd7
    } cfg_reg_t;

    localparam logic [SHORT_W-1:0] RST_FIRST_HIGH  = 8'd2;
    localparam logic [SHORT_W-1:0] RST_FIRST_LOW   = 8'd2;
    localparam logic [SHORT_W-1:0] RST_SECOND_HIGH = 8'd2;
    localparam logic [SHORT_W-1:0] RST_ONE_TAIL    = 8'd1;
    localparam logic [SHORT_W-1:0] RST_ZERO_TAIL   = 8'd3;
    localparam logic [LONG_W-1:0]  RST_END_WAIT    = 12'd28;
    localparam logic [LONG_W-1:0]  RST_LATCH_WAIT  = 12'd140;
    localparam logic [LONG_W-1:0]  RST_COMMAND     = 12'h3AA;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BIT   = 2'd1,
        ST_END   = 2'd2,
        ST_LATCH = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        PH_HIGH1 = 2'd0,
        PH_LOW1  = 2'd1,
        PH_HIGH2 = 2'd2,
        PH_TAIL  = 2'd3
    } phase_t;

    // Frame = command, red, green, blue; leading FRAME_BITS kept, zero padded.
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [LONG_W-1:0]  command,
        input logic [LEVEL_W-1:0] red,
        input logic [LEVEL_W-1:0] green,
        input logic [LEVEL_W-1:0] blue
    );
        logic [FULL_BITS-1:0]            full;
        logic [FULL_BITS+FRAME_BITS-1:0] ext;
        full = {WORD_BITS'(command), WORD_BITS'(red), WORD_BITS'(green),
                WORD_BITS'(blue)};
        ext  = {full, {FRAME_BITS{1'b0}}};
        return ext[FULL_BITS+FRAME_BITS-1 -: FRAME_BITS];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/single_wire_led_frame_serializer.sv */
// Top level: single-wire pulse-coded RGB grayscale frame serializer.
// The result of an item is registered and is on m_* in the cycle after the item is taken.
// Throughput: one item per cycle unless the output stalls; the tick step is a single registered pass.
// The output register frees s_tready whenever m_tready is high or it is empty.
// Reset (synchronous, aresetn low): idle, line low, registers to defaults.
`default_nettype none

module single_wire_led_frame_serializer
    import swlfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // item input
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // red_level, green_level, blue_level, pad
    input  wire logic                  s_tuser,   // op (0 tick, 1 start)

    // result output
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata,   // line_level, pad
    output      logic [M_TUSER_W-1:0]  m_tuser,   // busy_res, start_taken, frame_done

    // register writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SHORT_W-1:0] first_high_reg, first_low_reg, second_high_reg;
    logic [SHORT_W-1:0] one_tail_reg, zero_tail_reg;
    logic [LONG_W-1:0]  end_wait_reg, latch_wait_reg, command_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_high_reg  <= RST_FIRST_HIGH;
            first_low_reg   <= RST_FIRST_LOW;
            second_high_reg <= RST_SECOND_HIGH;
            one_tail_reg    <= RST_ONE_TAIL;
            zero_tail_reg   <= RST_ZERO_TAIL;
            end_wait_reg    <= RST_END_WAIT;
            latch_wait_reg  <= RST_LATCH_WAIT;
            command_reg     <= RST_COMMAND;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FIRST_HIGH:  first_high_reg  <= cfg_wdata[SHORT_W-1:0];
                REG_FIRST_LOW:   first_low_reg   <= cfg_wdata[SHORT_W-1:0];
                REG_SECOND_HIGH: second_high_reg <= cfg_wdata[SHORT_W-1:0];
                REG_ONE_TAIL:    one_tail_reg    <= cfg_wdata[SHORT_W-1:0];
                REG_ZERO_TAIL:   zero_tail_reg   <= cfg_wdata[SHORT_W-1:0];
                REG_END_WAIT:    end_wait_reg    <= cfg_wdata[LONG_W-1:0];
                REG_LATCH_WAIT:  latch_wait_reg  <= cfg_wdata[LONG_W-1:0];
                REG_COMMAND:     command_reg     <= cfg_wdata[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Item fields and handshake
    // ---------------------------------------------------------------
    logic                op_start;
    logic [LEVEL_W-1:0]  red_level, green_level, blue_level;
    logic                step;

    assign op_start    = s_tuser;
    assign red_level   = s_tdata[LEVEL_W-1:0];
    assign green_level = s_tdata[2*LEVEL_W-1:LEVEL_W];
    assign blue_level  = s_tdata[3*LEVEL_W-1:2*LEVEL_W];

    logic m_valid_reg;
    // Result register takes a new item whenever it is empty or drains now.
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Waveform state
    // ---------------------------------------------------------------
    stage_t              stage_reg, stage_next;
    phase_t              phase_reg, phase_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0]   bits_left_reg, bits_left_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                line_reg, line_next;

    logic                top_bit;
    logic [LONG_W-1:0]   len_sel;
    logic [COUNT_W:0]    count_inc;
    logic                tick_hit;
    logic [BITS_W-1:0]   bits_dec;
    logic                level;
    logic                taken;
    logic                done;

    assign top_bit = shift_reg[FRAME_BITS-1];

    // Length of the current segment; a zero pulse or wait still lasts a tick, a zero tail is skipped.
    always_comb begin
        len_sel = LONG_W'(1);
        unique case (stage_reg)
            ST_BIT: begin
                unique case (phase_reg)
                    PH_HIGH1: len_sel = (first_high_reg == '0) ? LONG_W'(1)
                                                               : LONG_W'(first_high_reg);
                    PH_LOW1:  len_sel = (first_low_reg == '0) ? LONG_W'(1)
                                                              : LONG_W'(first_low_reg);
                    PH_HIGH2: len_sel = (second_high_reg == '0) ? LONG_W'(1)
                                                                : LONG_W'(second_high_reg);
                    PH_TAIL:  len_sel = top_bit ? LONG_W'(one_tail_reg)
                                                : LONG_W'(zero_tail_reg);
                    default:  len_sel = LONG_W'(1);
                endcase
            end
            ST_END:   len_sel = (end_wait_reg == '0) ? LONG_W'(1) : end_wait_reg;
            ST_LATCH: len_sel = (latch_wait_reg == '0) ? LONG_W'(1) : latch_wait_reg;
            default:  len_sel = LONG_W'(1);
        endcase
    end

    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign tick_hit  = count_inc >= {1'b0, len_sel};
    assign bits_dec  = (bits_left_reg == '0) ? '0 : bits_left_reg - BITS_W'(1);

    // Next state
    always_comb begin
        stage_next     = stage_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        count_next     = count_reg;
        line_next      = line_reg;

        if (step) begin
            line_next = level;
            if (op_start) begin
                if (stage_reg == ST_IDLE) begin
                    shift_next     = build_frame(command_reg, red_level,
                                                 green_level, blue_level);
                    bits_left_next = BITS_W'(FRAME_BITS);
                    phase_next     = PH_HIGH1;
                    count_next     = '0;
                    stage_next     = ST_BIT;
                end
            end else begin
                count_next = tick_hit ? '0 : count_inc[COUNT_W-1:0];
                unique case (stage_reg)
                    ST_BIT: begin
                        if (tick_hit) begin
                            logic advance;
                            advance = 1'b0;
                            unique case (phase_reg)
                                PH_HIGH1: phase_next = PH_LOW1;
                                PH_LOW1: begin
                                    if (top_bit)                  phase_next = PH_HIGH2;
                                    else if (zero_tail_reg != '0) phase_next = PH_TAIL;
                                    else                          advance    = 1'b1;
                                end
                                PH_HIGH2: begin
                                    if (one_tail_reg != '0) phase_next = PH_TAIL;
                                    else                    advance    = 1'b1;
                                end
                                PH_TAIL:  advance = 1'b1;
                                default:  advance = 1'b1;
                            endcase
                            // next bit: shift out, count down the frame
                            if (advance) begin
                                shift_next     = {shift_reg[FRAME_BITS-2:0], 1'b0};
                                phase_next     = PH_HIGH1;
                                bits_left_next = bits_dec;
                                if (bits_dec == '0) stage_next = ST_END;
                            end
                        end
                    end
                    ST_END:   if (tick_hit) stage_next = ST_LATCH;
                    ST_LATCH: if (tick_hit) stage_next = ST_IDLE;
                    default: begin
                        stage_next = ST_IDLE;
                        count_next = count_reg;
                    end
                endcase
            end
        end
    end

    // Outputs of this step
    always_comb begin
        level = 1'b0;
        taken = 1'b0;
        done  = 1'b0;
        if (op_start) begin
            level = line_reg;              // a start spends no tick
            taken = (stage_reg == ST_IDLE);
        end else begin
            unique case (stage_reg)
                ST_BIT:   level = (phase_reg == PH_HIGH1) || (phase_reg == PH_HIGH2);
                ST_LATCH: done  = tick_hit;
                default:  level = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg     <= ST_IDLE;
            phase_reg     <= PH_HIGH1;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            count_reg     <= '0;
            line_reg      <= 1'b0;
        end else begin
            stage_reg     <= stage_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
            line_reg      <= line_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                 m_line_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_line_reg <= level;
            m_user_reg <= {done, taken, stage_next != ST_IDLE};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_line_reg};
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

/* rtl/core/swlfs_checker.sv */
// Checker on the serializer's ports, bound to the top level.
`default_nettype none
`include "single_wire_led_frame_serializer_macros.svh"

module swlfs_checker
    import swlfs_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser
);

    // stalled item holds
    `SWLFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an empty result register never blocks the input
    `SWLFS_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready)

    // an accepted start leaves a frame in progress
    `SWLFS_ASSERT_NOW(a_start_busy, aclk, aresetn, m_tvalid && m_tuser[1], m_tuser[0] && !m_tuser[2])

    // done ends the frame with the line low
    `SWLFS_ASSERT_NOW(a_done_idle, aclk, aresetn, m_tvalid && m_tuser[2], !m_tuser[0] && !m_tdata[0])

    // line is low whenever idle
    `SWLFS_ASSERT_NOW(a_idle_low, aclk, aresetn, m_tvalid && !m_tuser[0], !m_tdata[0])

endmodule

bind single_wire_led_frame_serializer swlfs_checker u_swlfs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire
